@@ hdl/pat_pkg.sv @@
package pat_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GATE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STROBE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_MAP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd6;

	localparam logic [1:0] MODE_PHASE = 2'd0;
	localparam logic [1:0] MODE_INV   = 2'd1;
	localparam logic [1:0] MODE_DUAL  = 2'd2;
	localparam logic [1:0] MODE_IDLE  = 2'd3;

	localparam logic signed [1:0] LVL_PLUS  = 2'sb01;
	localparam logic signed [1:0] LVL_ZERO  = 2'sb00;
	localparam logic signed [1:0] LVL_MINUS = 2'sb11;

	localparam logic signed [63:0] PI_Q32  = 64'sh0000_0003_243F_6A89;
	localparam logic [31:0]        PI_Q30  = 32'hC90F_DAA2;
	localparam logic signed [63:0] I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;

	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int DEN_W  = 45;

	typedef logic signed [PROD_W-1:0] prod_t;

	// Saturate a wide signed value to the signed 32-bit range.
	function automatic logic signed [31:0] clamp32(input logic signed [PROD_W-1:0] x);
		logic signed [31:0] r;
		if (x > PROD_W'(64'sd2147483647)) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < -PROD_W'(64'sd2147483648)) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	// 64-bit signed add that saturates at both ends.
	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		logic signed [63:0] r;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			r = s[64] ? I64_MIN : I64_MAX;
		end else begin
			r = s[63:0];
		end
		return r;
	endfunction

endpackage

@@ hdl/pat_if.sv @@
interface pat_stim_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] freq_a;
	logic signed [31:0] freq_b;
	logic               force_tick;
	logic               hold;

	modport source (output valid, freq_a, freq_b, force_tick, hold, input ready);
	modport sink (input valid, freq_a, freq_b, force_tick, hold, output ready);
endinterface

interface pat_res_if;
	logic              valid;
	logic              ready;
	logic signed [1:0] level;
	logic              tick;
	logic [31:0]       tick_period;

	modport source (output valid, level, tick, tick_period, input ready);
	modport sink (input valid, level, tick, tick_period, output ready);
endinterface

@@ hdl/pat_mul.sv @@
module pat_mul
	import pat_pkg::*;
(
	input  logic                    clk,
	input  logic signed [MUL_W-1:0] a,
	input  logic signed [MUL_W-1:0] b,
	output prod_t                   p
);

	prod_t p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

@@ hdl/pat_div.sv @@
module pat_div
	import pat_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [63:0]      num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [63:0]      quo
);

	logic             busy_q;
	logic             done_q;
	logic [5:0]       cnt_q;
	logic [63:0]      num_q;
	logic [63:0]      quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// One quotient bit per cycle, most significant first.
	assign trial = {rem_q[DEN_W-1:0], num_q[63]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], 1'b0};
			rem_q <= fits ? trial - {1'b0, den_q} : trial;
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

@@ hdl/phase_accumulator_tick_generator.sv @@
// Phase accumulator tick generator.
// Each beat on the stimulus channel is one time step carrying two frequency
// samples and the force_tick and hold flags. Each step yields exactly one beat
// on the result channel with the output level, a tick flag and the number of
// steps between the last two ticks.
// Configuration is written through wr_en, wr_index and wr_data; the user must
// write it only while the block is idle, which the block does not enforce.
// Registers: mode, gate/strobe flags, freq map enable, step time, base freq, gain.
// A step is handled by a small sequencer around one registered 33x33 multiplier
// and a radix-2 divider. Phase mode integrates one phase accumulator, dual mode
// both and idle mode none before the result beat; the frequency map adds two
// passes of four states. Mode 1 runs the divider and a three-multiply squaring,
// after the map if it is enabled. Only one step is in flight: a new step is
// accepted only once the last one has loaded its result.
// Reset clears the phase and time accumulators, the step counter, the output
// state and the configuration to its defaults. When the receiver stalls, the
// finished result holds in the output register and the sequencer waits before
// retiring the next step, so no beat is lost.
module phase_accumulator_tick_generator
	import pat_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	pat_stim_if.sink              stimulus,
	pat_res_if.source             result
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MAP0 = 4'd1;
	localparam logic [3:0] S_MAP1 = 4'd2;
	localparam logic [3:0] S_MAP2 = 4'd3;
	localparam logic [3:0] S_MAP3 = 4'd4;
	localparam logic [3:0] S_PH   = 4'd5;
	localparam logic [3:0] S_PA   = 4'd6;
	localparam logic [3:0] S_PB   = 4'd7;
	localparam logic [3:0] S_DST  = 4'd8;
	localparam logic [3:0] S_DWT  = 4'd9;
	localparam logic [3:0] S_Q0   = 4'd10;
	localparam logic [3:0] S_Q1   = 4'd11;
	localparam logic [3:0] S_Q2   = 4'd12;
	localparam logic [3:0] S_Q3   = 4'd13;
	localparam logic [3:0] S_DEC  = 4'd14;

	// Configuration registers.
	logic [1:0]         mode_q;
	logic [1:0]         gate_q;
	logic [3:0]         strobe_q;
	logic               map_q;
	logic [31:0]        step_q;
	logic signed [31:0] base_q;
	logic signed [31:0] gain_q;

	// Accumulator state.
	logic signed [63:0] pm_q;
	logic signed [63:0] ps_q;
	logic [63:0]        el_q;
	logic [31:0]        steps_q;
	logic [31:0]        period_q;
	logic               out_state_q;

	// Per-step working registers.
	logic [3:0]         state_q;
	logic               sel_q;
	logic signed [31:0] fa_q;
	logic signed [31:0] fb_q;
	logic signed [31:0] g_q;
	logic               force_q;
	logic               hold_q;
	logic [127:0]       acc_q;

	// Result register.
	logic               res_valid_q;
	logic signed [1:0]  res_level_q;
	logic               res_tick_q;
	logic [31:0]        res_period_q;

	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	prod_t                   prod;
	prod_t                   prod_sh;
	logic signed [63:0]      pstep;
	logic [64:0]             el_sum;
	logic signed [31:0]      f_sel;
	logic                    div_start;
	logic                    div_done;
	logic [63:0]             div_quo;
	logic                    in_fire;
	logic                    out_free;
	logic                    rst_w;
	logic                    lck_w;
	logic                    g1;
	logic                    g2;
	logic                    tick_w;
	logic                    out_next;
	logic signed [1:0]       lvl_v;
	logic signed [1:0]       lvl_w;

	assign in_fire  = stimulus.valid && stimulus.ready;
	assign out_free = !res_valid_q || result.ready;
	assign stimulus.ready = (state_q == S_IDLE);

	assign f_sel   = sel_q ? fb_q : fa_q;
	assign prod_sh = prod >>> 16;
	// The phase step is the product shifted down by 16, truncated to 64 bits.
	assign pstep   = prod_sh[63:0];
	assign el_sum  = {1'b0, el_q} + {33'b0, step_q};

	// Operand selection for the shared multiplier; the product is registered and appears in the next cycle.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MAP0: begin
				mul_a = {f_sel[31], f_sel};
				mul_b = {gain_q[31], gain_q};
			end
			S_MAP2: begin
				mul_a = {base_q[31], base_q};
				mul_b = {g_q[31], g_q};
			end
			S_PH: begin
				if (mode_q == MODE_INV) begin
					mul_a = {1'b0, step_q};
					mul_b = {1'b0, PI_Q30};
				end else begin
					mul_a = {fa_q[31], fa_q};
					mul_b = {1'b0, step_q};
				end
			end
			S_PA: begin
				mul_a = {fb_q[31], fb_q};
				mul_b = {1'b0, step_q};
			end
			S_Q0: begin
				mul_a = {1'b0, el_q[31:0]};
				mul_b = {1'b0, el_q[31:0]};
			end
			S_Q1: begin
				mul_a = {1'b0, el_q[63:32]};
				mul_b = {1'b0, el_q[31:0]};
			end
			S_Q2: begin
				mul_a = {1'b0, el_q[63:32]};
				mul_b = {1'b0, el_q[63:32]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	pat_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign div_start = (state_q == S_DST);

	// The denominator is the clamped frequency shifted up by 14.
	pat_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod[63:0]),
		.den    ({fa_q[30:0], 14'b0}),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Tick decision, evaluated on the accumulated values in the final state.
	always_comb begin
		rst_w  = gate_q[0] && force_q;
		lck_w  = gate_q[1] && hold_q;
		g1     = pm_q > PI_Q32;
		g2     = ps_q > PI_Q32;
		tick_w = 1'b0;
		lvl_w  = LVL_ZERO;
		unique case (mode_q)
			MODE_PHASE: tick_w = rst_w || (!lck_w && g1);
			MODE_INV:   tick_w = rst_w || (!lck_w &&
				(pm_q[63] || acc_q > {32'b0, pm_q, 32'b0}));
			MODE_DUAL:  tick_w = rst_w || (!lck_w && g1 && g2);
			MODE_IDLE:  tick_w = 1'b0;
			default:    tick_w = 1'b0;
		endcase
		out_next = tick_w ? !out_state_q : out_state_q;
		lvl_v    = out_next ? LVL_PLUS : (strobe_q[3] ? LVL_ZERO : LVL_MINUS);
		if (mode_q == MODE_DUAL) begin
			if (rst_w || lck_w || (g1 == g2)) begin
				lvl_w = LVL_ZERO;
			end else begin
				lvl_w = g1 ? LVL_PLUS : LVL_MINUS;
			end
		end else if (!strobe_q[0]) begin
			lvl_w = lvl_v;
		end else if (!tick_w) begin
			lvl_w = LVL_ZERO;
		end else if (strobe_q[2] && lvl_v != LVL_PLUS) begin
			lvl_w = LVL_ZERO;
		end else begin
			lvl_w = strobe_q[1] ? lvl_v : LVL_PLUS;
		end
	end

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PHASE;
			gate_q   <= '0;
			strobe_q <= '0;
			map_q    <= 1'b0;
			step_q   <= 32'd42950;
			base_q   <= 32'sd65536;
			gain_q   <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODE:     mode_q   <= wr_data[1:0];
				REG_GATE:     gate_q   <= wr_data[1:0];
				REG_STROBE:   strobe_q <= wr_data[3:0];
				REG_FREQ_MAP: map_q    <= wr_data[0];
				REG_STEP:     step_q   <= wr_data;
				REG_BASE:     base_q   <= wr_data;
				REG_GAIN:     gain_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// Sequencer and accumulator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= 1'b0;
			pm_q        <= '0;
			ps_q        <= '0;
			el_q        <= '0;
			steps_q     <= '0;
			period_q    <= '0;
			out_state_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			// A new result loads the output register; otherwise a taken beat empties it.
			if (state_q == S_DEC && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						sel_q   <= 1'b0;
						state_q <= S_MAP0;
					end
				end
				S_MAP0: state_q <= map_q ? S_MAP1 : S_PH;
				S_MAP1: state_q <= S_MAP2;
				S_MAP2: state_q <= S_MAP3;
				S_MAP3: begin
					sel_q   <= 1'b1;
					state_q <= sel_q ? S_PH : S_MAP0;
				end
				S_PH: begin
					unique case (mode_q)
						MODE_INV: begin
							el_q    <= el_sum[63] ? I64_MAX : el_sum[63:0];
							state_q <= S_DST;
						end
						MODE_IDLE: state_q <= S_DEC;
						default:   state_q <= S_PA;
					endcase
				end
				S_PA: begin
					pm_q    <= sat_add64(pm_q, pstep);
					state_q <= (mode_q == MODE_DUAL) ? S_PB : S_DEC;
				end
				S_PB: begin
					ps_q    <= sat_add64(ps_q, pstep);
					state_q <= S_DEC;
				end
				S_DST: state_q <= S_DWT;
				S_DWT: begin
					if (div_done) begin
						pm_q    <= sat_add64(pm_q, div_quo);
						state_q <= S_Q0;
					end
				end
				S_Q0: state_q <= S_Q1;
				S_Q1: state_q <= S_Q2;
				S_Q2: state_q <= S_Q3;
				S_Q3: state_q <= S_DEC;
				S_DEC: begin
					if (out_free) begin
						out_state_q <= out_next;
						if (tick_w) begin
							pm_q     <= '0;
							ps_q     <= '0;
							el_q     <= '0;
							period_q <= steps_q;
							steps_q  <= 32'd1;
						end else if (steps_q != '1) begin
							steps_q <= steps_q + 32'd1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers without reset.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			fa_q    <= stimulus.freq_a;
			fb_q    <= stimulus.freq_b;
			force_q <= stimulus.force_tick;
			hold_q  <= stimulus.hold;
		end
		if (state_q == S_MAP1) begin
			g_q <= clamp32(prod_sh + PROD_W'(65536));
		end
		if (state_q == S_MAP3) begin
			if (sel_q) begin
				fb_q <= clamp32(prod_sh);
			end else begin
				fa_q <= clamp32(prod_sh);
			end
		end
		// Inverse-frequency mode clamps a non-positive frequency to one LSB.
		if (state_q == S_PH && mode_q == MODE_INV && (fa_q[31] || fa_q == '0)) begin
			fa_q <= 32'sd1;
		end
		if (state_q == S_Q1) begin
			acc_q <= {64'b0, prod[63:0]};
		end
		if (state_q == S_Q2) begin
			acc_q <= acc_q + {31'b0, prod[63:0], 33'b0};
		end
		if (state_q == S_Q3) begin
			acc_q <= acc_q + {prod[63:0], 64'b0};
		end
		if (state_q == S_DEC && out_free) begin
			res_level_q  <= lvl_w;
			res_tick_q   <= tick_w;
			res_period_q <= tick_w ? steps_q : period_q;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.level       = res_level_q;
	assign result.tick        = res_tick_q;
	assign result.tick_period = res_period_q;

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DWT)
		else $error("divider finished outside its wait state");

	a_tick_restarts_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEC && out_free && tick_w) |=> steps_q == 32'd1 && pm_q == '0)
		else $error("tick did not clear the accumulators");

	a_one_step_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !stimulus.ready)
		else $error("stimulus accepted while a step is in flight");

	a_dual_only_second: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PB) |-> mode_q == MODE_DUAL)
		else $error("second phase integrated outside dual mode");

endmodule
